@@ rtl/core/int_vec3_alu_unit_macros.svh @@
// Assertion macros shared by the checker of the vector ALU.
`ifndef INT_VEC3_ALU_UNIT_MACROS_SVH
`define INT_VEC3_ALU_UNIT_MACROS_SVH

// Checked only while out of reset.
`define IVALU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define IVALU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ivalu_pkg.sv @@
// Shared widths, stage counts and command codes of the vector ALU.
package ivalu_pkg;
  localparam int CW     = 16;
  localparam int CMD_W  = 3;
  localparam int RES_W  = 32;
  localparam int LEN_W  = 17;
  localparam int SQ_W   = 32;
  localparam int SUM_W  = 2 * LEN_W;
  localparam int NSTG   = 3 + LEN_W;

  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MAG  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DIST = 3'd5;
endpackage

@@ rtl/core/ivalu_lane.sv @@
// One component lane: add, subtract, multiply, pipelined divide and squared magnitude or difference.
module ivalu_lane import ivalu_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [CMD_W-1:0]        cmd,
  input  logic signed [CW-1:0]    a,
  input  logic signed [CW-1:0]    b,
  output logic [SQ_W-1:0]         sq,
  output logic signed [RES_W-1:0] res,
  output logic                    dz
);
  logic signed [CW:0]      a_e, b_e, sum_e, dif_e, src_e;
  logic signed [2*CW-1:0]  prod;
  logic [CW:0]             mag;
  logic [CW-1:0]           na, nb;
  logic signed [RES_W-1:0] res_s1;
  logic                    isdiv;
  logic [2*CW+1:0]         sq_full;
  logic signed [RES_W-1:0] qres;

  logic signed [RES_W-1:0] res_r [1:NSTG];
  logic                    dz_r  [1:NSTG];
  logic                    div_r [1:CW+1];
  logic                    neg_r [1:CW+1];
  logic [CW-1:0]           rem_r [1:CW+1];
  logic [CW-1:0]           quo_r [1:CW+1];
  logic [CW-1:0]           dsr_r [1:CW+1];
  logic [CW:0]             mag_r;
  logic [SQ_W-1:0]         sq_r;

  always_comb begin
    a_e    = {a[CW-1], a};
    b_e    = {b[CW-1], b};
    sum_e  = a_e + b_e;
    dif_e  = a_e - b_e;
    prod   = a * b;
    na     = a[CW-1] ? CW'(-a_e) : a;
    nb     = b[CW-1] ? CW'(-b_e) : b;
    res_s1 = '0;
    isdiv  = 1'b0;
    src_e  = '0;
    unique case (cmd)
      CMD_ADD:  res_s1 = RES_W'(sum_e);
      CMD_SUB:  res_s1 = RES_W'(dif_e);
      CMD_MUL:  res_s1 = RES_W'(prod);
      CMD_DIV:  isdiv  = 1'b1;
      CMD_MAG:  src_e  = a_e;
      CMD_DIST: src_e  = -dif_e;
      default:  ;
    endcase
    mag = src_e[CW] ? (CW+1)'(-src_e) : src_e;
  end

  assign sq_full = mag_r * mag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      res_r[1] <= res_s1;
      dz_r[1]  <= isdiv && (b == '0);
      div_r[1] <= isdiv;
      neg_r[1] <= a[CW-1] ^ b[CW-1];
      rem_r[1] <= '0;
      quo_r[1] <= na;
      dsr_r[1] <= nb;
      mag_r    <= mag;
      sq_r     <= sq_full[SQ_W-1:0];
    end
  end

  // Restoring divider, one quotient bit per stage; quotient bits shift into quo_r.
  for (genvar k = 1; k <= CW; k++) begin : g_div
    logic [CW:0] t, d;
    assign t = {rem_r[k], quo_r[k][CW-1]};
    assign d = t - {1'b0, dsr_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= d[CW] ? t[CW-1:0] : d[CW-1:0];
        quo_r[k+1] <= {quo_r[k][CW-2:0], ~d[CW]};
        dsr_r[k+1] <= dsr_r[k];
        div_r[k+1] <= div_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  always_comb begin
    if (dz_r[CW+1]) begin
      qres = '0;
    end else if (neg_r[CW+1]) begin
      qres = -RES_W'(quo_r[CW+1]);
    end else begin
      qres = RES_W'(quo_r[CW+1]);
    end
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dz_r[k+1] <= dz_r[k];
        if (k + 1 == CW + 2) begin
          res_r[k+1] <= div_r[CW+1] ? qres : res_r[k];
        end else begin
          res_r[k+1] <= res_r[k];
        end
      end
    end
  end

  assign sq  = sq_r;
  assign res = res_r[NSTG];
  assign dz  = dz_r[NSTG];
endmodule

@@ rtl/core/ivalu_merge.sv @@
// Merging stage: sums the lane squares and takes a pipelined integer square root.
module ivalu_merge import ivalu_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SQ_W-1:0]  sq_x,
  input  logic [SQ_W-1:0]  sq_y,
  input  logic [SQ_W-1:0]  sq_z,
  output logic [LEN_W-1:0] length
);
  localparam int REM_W = LEN_W + 1;

  logic [SUM_W-1:0] rad_r  [0:LEN_W];
  logic [REM_W-1:0] rem_r  [0:LEN_W];
  logic [LEN_W-1:0] root_r [0:LEN_W];

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  // Two radicand bits enter per stage and one root bit leaves.
  for (genvar k = 0; k < LEN_W; k++) begin : g_sqrt
    logic [REM_W+1:0] t, trial, d;
    logic             ge;
    assign t     = {rem_r[k], rad_r[k][SUM_W-1 -: 2]};
    assign trial = (REM_W+2)'({root_r[k], 2'b01});
    assign d     = t - trial;
    assign ge    = (t >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? d[REM_W-1:0] : t[REM_W-1:0];
        root_r[k+1] <= {root_r[k][LEN_W-2:0], ge};
        rad_r[k+1]  <= SUM_W'(rad_r[k] << 2);
      end
    end
  end

  assign length = root_r[LEN_W];
endmodule

@@ rtl/core/int_vec3_alu_unit.sv @@
// Top level of the three-component integer vector ALU.
// Input channel in_*: a command and two signed 16-bit vectors a and b, one request
// per valid/ready handshake. Output channel out_*: one result per request, in order:
// lane results res_x/y/z for add, subtract, multiply and divide, length for the
// magnitude of a or the distance between a and b, and div_zero when a divide met
// a zero divisor in any lane (that lane then reads zero).
// Throughput: one request per cycle while the output is not stalled. The depth is
// set by the 16-stage divider in each lane and the 17-stage square root in the
// merging stage, both fully pipelined.
// The whole pipeline advances together; the output register is its last stage, so
// a new request is still taken while a finished result waits, as long as the
// output register is empty or being read in the same cycle.
// When the receiver stalls, the output holds steady and the pipeline freezes;
// in_ready drops until the result is taken.
// Synchronous active-low reset clears the valid bits; no result is shown after it.
module int_vec3_alu_unit import ivalu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic signed [CW-1:0]    in_a_x,
  input  logic signed [CW-1:0]    in_a_y,
  input  logic signed [CW-1:0]    in_a_z,
  input  logic signed [CW-1:0]    in_b_x,
  input  logic signed [CW-1:0]    in_b_y,
  input  logic signed [CW-1:0]    in_b_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [RES_W-1:0] out_res_x,
  output logic signed [RES_W-1:0] out_res_y,
  output logic signed [RES_W-1:0] out_res_z,
  output logic [LEN_W-1:0]        out_length,
  output logic                    out_div_zero
);
  logic                    en;
  logic                    v_r [1:NSTG];
  logic                    out_valid_r;
  logic [SQ_W-1:0]         sq_x, sq_y, sq_z;
  logic signed [RES_W-1:0] res_x, res_y, res_z;
  logic                    dz_x, dz_y, dz_z;
  logic [LEN_W-1:0]        length;
  logic signed [RES_W-1:0] res_x_r, res_y_r, res_z_r;
  logic [LEN_W-1:0]        length_r;
  logic                    div_zero_r;

  assign en = !out_valid_r || out_ready;

  ivalu_lane u_lane_x (.clk, .en, .cmd(in_cmd), .a(in_a_x), .b(in_b_x),
                       .sq(sq_x), .res(res_x), .dz(dz_x));
  ivalu_lane u_lane_y (.clk, .en, .cmd(in_cmd), .a(in_a_y), .b(in_b_y),
                       .sq(sq_y), .res(res_y), .dz(dz_y));
  ivalu_lane u_lane_z (.clk, .en, .cmd(in_cmd), .a(in_a_z), .b(in_b_z),
                       .sq(sq_z), .res(res_z), .dz(dz_z));

  ivalu_merge u_merge (.clk, .en, .sq_x, .sq_y, .sq_z, .length);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NSTG];
    end
  end

  for (genvar k = 1; k <= NSTG; k++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        if (k == 1) begin
          v_r[k] <= in_valid;
        end else begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x_r    <= res_x;
      res_y_r    <= res_y;
      res_z_r    <= res_z;
      length_r   <= length;
      div_zero_r <= dz_x | dz_y | dz_z;
    end
  end

  assign in_ready     = en;
  assign out_valid    = out_valid_r;
  assign out_res_x    = res_x_r;
  assign out_res_y    = res_y_r;
  assign out_res_z    = res_z_r;
  assign out_length   = length_r;
  assign out_div_zero = div_zero_r;
endmodule

@@ rtl/core/ivalu_checker.sv @@
// Port-level checker of the vector ALU and its bind to the top level.
`include "int_vec3_alu_unit_macros.svh"
module ivalu_checker import ivalu_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [RES_W-1:0] out_res_x,
  input logic signed [RES_W-1:0] out_res_y,
  input logic signed [RES_W-1:0] out_res_z,
  input logic [LEN_W-1:0]        out_length,
  input logic                    out_div_zero
);
  `IVALU_ASSERT_ALWAYS(a_rst_clears, !rst_n |=> !out_valid, "result shown after reset")
  `IVALU_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_res_x)
    && $stable(out_length) && $stable(out_div_zero), "stalled result changed")
  `IVALU_ASSERT(a_len_only, out_valid && out_length != '0 |-> out_res_x == '0
    && out_res_y == '0 && out_res_z == '0 && !out_div_zero, "length mixed with lanes")
  `IVALU_ASSERT(a_dz_len, out_valid && out_div_zero |-> out_length == '0,
    "divide flag with length")
  `IVALU_ASSERT(a_ready, !out_valid |-> in_ready, "request refused with empty output")
endmodule

bind int_vec3_alu_unit ivalu_checker u_ivalu_checker (.*);

@@ bench/testbench.sv @@
// Self-checking testbench for the three-component integer vector ALU.
module testbench;
  import ivalu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CMD_W-1:0]     cmd;
    logic signed [CW-1:0] a [3];
    logic signed [CW-1:0] b [3];
    bit                   typed;
  } vec_req_t;

  typedef struct {
    logic signed [RES_W-1:0] r [3];
    logic [LEN_W-1:0]        len;
    logic                    dz;
  } vec_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_cmd = '0;
  logic signed [CW-1:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [CW-1:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [RES_W-1:0] out_res_x, out_res_y, out_res_z;
  logic [LEN_W-1:0] out_length;
  logic out_div_zero;

  vec_req_t req_q [$];
  vec_res_t typed_q [$];
  vec_res_t want_q [$];
  vec_req_t cur_req;
  vec_res_t cur_typed;
  int unsigned cyc = 0;
  int errors = 0;
  bit all_sent = 1'b0;

  int_vec3_alu_unit i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic vec_res_t predict_vec3(vec_req_t q);
    vec_res_t p;
    longint signed ai, bi, d;
    longint unsigned sum = 0;
    p.dz = 1'b0;
    p.len = '0;
    for (int i = 0; i < 3; i++) begin
      ai = q.a[i];
      bi = q.b[i];
      p.r[i] = '0;
      case (q.cmd)
        CMD_ADD: p.r[i] = RES_W'(ai + bi);
        CMD_SUB: p.r[i] = RES_W'(ai - bi);
        CMD_MUL: p.r[i] = RES_W'(ai * bi);
        CMD_DIV: begin
          if (bi == 0) p.dz = 1'b1;
          else p.r[i] = RES_W'(ai / bi);
        end
        CMD_MAG: sum += ai * ai;
        CMD_DIST: begin
          d = bi - ai;
          sum += d * d;
        end
        default: ;
      endcase
    end
    if (q.cmd == CMD_MAG || q.cmd == CMD_DIST) p.len = LEN_W'(floor_sqrt(sum));
    return p;
  endfunction

  function automatic vec_req_t mk_req(logic [CMD_W-1:0] c, int ax, int ay, int az,
                                      int bx, int by, int bz);
    vec_req_t q;
    q.cmd = c;
    q.a[0] = CW'(ax); q.a[1] = CW'(ay); q.a[2] = CW'(az);
    q.b[0] = CW'(bx); q.b[1] = CW'(by); q.b[2] = CW'(bz);
    q.typed = 1'b0;
    return q;
  endfunction

  function automatic vec_res_t mk_res(int rx, int ry, int rz, int len, bit dz);
    vec_res_t p;
    p.r[0] = rx; p.r[1] = ry; p.r[2] = rz;
    p.len = LEN_W'(len);
    p.dz = dz;
    return p;
  endfunction

  task automatic add_row(vec_req_t q, bit typed, vec_res_t p);
    q.typed = typed;
    req_q.push_back(q);
    if (typed) typed_q.push_back(p);
  endtask

  function automatic logic signed [CW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3, 4: return CW'($urandom_range(0, 15)) - 16'sd8;
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic build_stimulus();
    vec_req_t q;
    vec_res_t none;
    none = mk_res(0, 0, 0, 0, 0);
    // Directed rows: extremes, every command, zero divisors and unused codes.
    add_row(mk_req(CMD_ADD, 0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 0));
    add_row(mk_req(CMD_ADD, 32767, -32768, 32767, 32767, -32768, -32768), 1,
            mk_res(65534, -65536, -1, 0, 0));
    add_row(mk_req(CMD_SUB, -32768, 32767, 0, 32767, -32768, 0), 1,
            mk_res(-65535, 65535, 0, 0, 0));
    add_row(mk_req(CMD_MUL, -32768, -32768, 32767, -32768, 32767, 32767), 1,
            mk_res(1073741824, -1073709056, 1073676289, 0, 0));
    add_row(mk_req(CMD_DIV, -32768, 7, -7, -1, 2, 2), 1, mk_res(32768, 3, -3, 0, 0));
    add_row(mk_req(CMD_DIV, 5, 9, -9, 0, 4, 0), 1, mk_res(0, 2, 0, 0, 1));
    add_row(mk_req(CMD_DIV, 0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 1));
    add_row(mk_req(CMD_MAG, 3, 4, 0, 99, 99, 99), 1, mk_res(0, 0, 0, 5, 0));
    add_row(mk_req(CMD_MAG, -32768, -32768, -32768, 0, 0, 0), 1,
            mk_res(0, 0, 0, 56755, 0));
    add_row(mk_req(CMD_DIST, 1, 2, 3, 1, 2, 3), 1, mk_res(0, 0, 0, 0, 0));
    add_row(mk_req(CMD_DIST, -32768, -32768, -32768, 32767, 32767, 32767), 1,
            mk_res(0, 0, 0, 113509, 0));
    add_row(mk_req(3'd6, 12, 34, 56, 7, 8, 9), 1, none);
    add_row(mk_req(3'd7, -1, -1, -1, -1, -1, -1), 1, none);
    add_row(mk_req(CMD_DIV, -100, 100, -1, 7, -7, 32767), 0, none);
    add_row(mk_req(CMD_MAG, 32767, -1, 1, 0, 0, 0), 0, none);
    add_row(mk_req(CMD_DIST, 5, -5, 32767, -5, 5, -32768), 0, none);
    add_row(mk_req(CMD_MUL, -1, 255, -256, 1, -255, 256), 0, none);
    for (int n = 0; n < 400; n++) begin
      q.cmd = ($urandom_range(0, 19) == 0) ? CMD_W'($urandom_range(6, 7))
                                           : CMD_W'($urandom_range(0, 5));
      for (int i = 0; i < 3; i++) begin
        q.a[i] = rand_comp();
        q.b[i] = rand_comp();
      end
      q.typed = 1'b0;
      req_q.push_back(q);
    end
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Sender: one request held until taken; random gaps, none in the quiet window.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (cur_req.typed) want_q.push_back(cur_typed);
        else want_q.push_back(predict_vec3(cur_req));
      end
      if (!in_valid || in_ready) begin
        if (req_q.size() != 0 && !((cyc < 100 || cyc > 250) &&
                                   $urandom_range(0, 99) < 6)) begin
          cur_req = req_q.pop_front();
          if (cur_req.typed) cur_typed = typed_q.pop_front();
          in_valid <= 1'b1;
          in_cmd <= cur_req.cmd;
          in_a_x <= cur_req.a[0]; in_a_y <= cur_req.a[1]; in_a_z <= cur_req.a[2];
          in_b_x <= cur_req.b[0]; in_b_y <= cur_req.b[1]; in_b_z <= cur_req.b[2];
        end else begin
          in_valid <= 1'b0;
          if (req_q.size() == 0) all_sent <= 1'b1;
        end
      end
    end
  end

  // Receiver: random stalls, a long hold-off so the pipeline backs up.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding", $time);
        end else begin
          vec_res_t w;
          w = want_q.pop_front();
          check_field("res_x", w.r[0], out_res_x);
          check_field("res_y", w.r[1], out_res_y);
          check_field("res_z", w.r[2], out_res_z);
          check_field("length", w.len, out_length);
          check_field("div_zero", w.dz, out_div_zero);
        end
      end
      if (cyc >= 300 && cyc < 500) out_ready <= 1'b0;
      else if (cyc >= 100 && cyc <= 250) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) >= 6);
    end
  end

  initial begin
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (all_sent && want_q.size() == 0);
    repeat (30) @(posedge clk);
    if (errors == 0 && want_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule
